[rtl/slfs_pkg.sv]
// Shared types and constants for the SPI panel window fill streamer.
// Holds command, job and register codes used by the front, queue, back and top.
// Depends on nothing.
package slfs_pkg;

	// Input command codes
	localparam logic [2:0] CMD_FILL_RECT    = 3'd0;
	localparam logic [2:0] CMD_FILL_SCREEN  = 3'd1;
	localparam logic [2:0] CMD_OPEN_WINDOW  = 3'd2;
	localparam logic [2:0] CMD_BITMAP_PIXEL = 3'd3;
	localparam logic [2:0] CMD_TICK         = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_COLUMN_CODE  = 3'd2;
	localparam logic [2:0] CFG_ROW_CODE     = 3'd3;
	localparam logic [2:0] CFG_MEMWR_CODE   = 3'd4;

	// Register widths and reset values
	localparam int PANEL_W       = 11;
	localparam int PANEL_REG_MAX = (1 << PANEL_W) - 1;
	localparam int CFG_DATA_W    = PANEL_W;
	localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 11'd240;
	localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 11'd320;
	localparam logic [7:0] COLUMN_CODE_RST = 8'h2A;
	localparam logic [7:0] ROW_CODE_RST    = 8'h2B;
	localparam logic [7:0] MEMWR_CODE_RST  = 8'h2C;

	// Defaults for the top-level parameters
	localparam int MAX_SIDE_DEFAULT    = 1024;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Pixel countdown width
	localparam int COUNT_W = 21;

	// Bytes per job kind
	localparam int WINDOW_BYTES = 11;
	localparam int BYTE_CNT_W   = $clog2(WINDOW_BYTES);
	localparam logic [BYTE_CNT_W-1:0] WINDOW_LAST_IDX = BYTE_CNT_W'(WINDOW_BYTES - 1);
	localparam logic [BYTE_CNT_W-1:0] PIXEL_LAST_IDX  = BYTE_CNT_W'(1);

	// Streaming modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_FILL   = 2'd1;
	localparam logic [1:0] MODE_BITMAP = 2'd2;

	// Job kinds handed from the front to the back
	typedef enum logic [1:0] {
		JOB_REJECT = 2'd0,
		JOB_WINDOW = 2'd1,
		JOB_PIXEL  = 2'd2
	} job_kind_t;

	// One job: everything the back needs to produce the words of one item
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] x0;
		logic [15:0] x1;
		logic [15:0] y0;
		logic [15:0] y1;
		logic [15:0] pix;
		logic        done;
	} job_t;

	// Command bytes the back sends around a window
	typedef struct packed {
		logic [7:0] column_code;
		logic [7:0] row_code;
		logic [7:0] memwr_code;
	} codes_t;

endpackage

[rtl/slfs_front.sv]
// Front part: accepts drawing commands, clips geometry, keeps stream state.
// Emits one job per accepted command. Depends on slfs_pkg.
module slfs_front
	import slfs_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PANEL_W-1:0]    panel_width,
	input  logic [PANEL_W-1:0]    panel_height,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_cmd,
	input  logic signed [12:0]    in_pos_x,
	input  logic signed [12:0]    in_pos_y,
	input  logic signed [12:0]    in_size_w,
	input  logic signed [12:0]    in_size_h,
	input  logic [15:0]           in_pixel,
	output logic                  job_valid,
	input  logic                  job_ready,
	output job_t                  job
);

	localparam int EFF_MAX = (MAX_SIDE < PANEL_REG_MAX) ? MAX_SIDE : PANEL_REG_MAX;
	localparam int SIDE_W  = $clog2(EFF_MAX + 1);
	localparam int CW      = 15;

	typedef struct packed {
		logic              ok;
		logic [SIDE_W-1:0] pos;
		logic [SIDE_W-1:0] len;
	} axis_t;

	// Clip one axis against the panel; a window must lie wholly on the panel.
	function automatic axis_t clip_axis(input logic signed [CW-1:0] p,
	                                    input logic signed [CW-1:0] s,
	                                    input logic signed [CW-1:0] lim,
	                                    input logic win);
		axis_t                r;
		logic signed [CW-1:0] cp;
		logic signed [CW-1:0] cs;
		logic signed [CW-1:0] room;
		logic signed [CW-1:0] clen;
		cp   = (p < 0) ? '0 : p;
		cs   = (p < 0) ? (s + p) : s;
		room = lim - cp;
		clen = (cs > room) ? room : cs;
		if (win) begin
			r.ok = (s > 0) && (p >= 0) && (p <= (lim - s));
		end else begin
			r.ok = (s > 0) && (cp < lim) && (cs > 0);
		end
		r.pos = SIDE_W'(cp);
		r.len = SIDE_W'(clen);
		return r;
	endfunction

	logic [SIDE_W-1:0]    pw;
	logic [SIDE_W-1:0]    ph;
	logic signed [CW-1:0] px_in;
	logic signed [CW-1:0] py_in;
	logic signed [CW-1:0] sw_in;
	logic signed [CW-1:0] sh_in;
	logic                 is_window;
	axis_t                ax;
	axis_t                ay;

	logic                 valid_s1;
	logic [2:0]           cmd_s1;
	logic                 ok_s1;
	logic [SIDE_W-1:0]    x_s1;
	logic [SIDE_W-1:0]    y_s1;
	logic [SIDE_W-1:0]    w_s1;
	logic [SIDE_W-1:0]    h_s1;
	logic [15:0]          pixel_s1;

	logic [COUNT_W-1:0]   pixels_left_q;
	logic [15:0]          fill_color_q;
	logic [1:0]           mode_q;

	logic [2*SIDE_W-1:0]  area;
	logic [SIDE_W-1:0]    x1;
	logic [SIDE_W-1:0]    y1;
	logic                 push;
	logic                 stream_ok;
	logic                 last_px;

	// Effective panel size, clamped to the largest supported side.
	always_comb begin
		pw = (int'(panel_width) > MAX_SIDE) ? SIDE_W'(EFF_MAX) : SIDE_W'(panel_width);
		ph = (int'(panel_height) > MAX_SIDE) ? SIDE_W'(EFF_MAX) : SIDE_W'(panel_height);
	end

	// Geometry selection: fill screen covers the whole panel.
	always_comb begin
		is_window = (in_cmd == CMD_OPEN_WINDOW);
		if (in_cmd == CMD_FILL_SCREEN) begin
			px_in = '0;
			py_in = '0;
			sw_in = CW'($signed({1'b0, pw}));
			sh_in = CW'($signed({1'b0, ph}));
		end else begin
			px_in = CW'(in_pos_x);
			py_in = CW'(in_pos_y);
			sw_in = CW'(in_size_w);
			sh_in = CW'(in_size_h);
		end
		ax = clip_axis(px_in, sw_in, CW'($signed({1'b0, pw})), is_window);
		ay = clip_axis(py_in, sh_in, CW'($signed({1'b0, ph})), is_window);
	end

	assign in_ready = !valid_s1 || job_ready;
	assign push     = valid_s1 && job_ready;

	// Stage one: classified and clipped command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= in_cmd;
			ok_s1    <= ax.ok && ay.ok;
			x_s1     <= ax.pos;
			y_s1     <= ay.pos;
			w_s1     <= ax.len;
			h_s1     <= ay.len;
			pixel_s1 <= in_pixel;
		end
	end

	// Window corners, pixel count and stream checks for the job.
	always_comb begin
		area      = w_s1 * h_s1;
		x1        = x_s1 + w_s1 - SIDE_W'(1);
		y1        = y_s1 + h_s1 - SIDE_W'(1);
		last_px   = (pixels_left_q == COUNT_W'(1));
		stream_ok = (pixels_left_q != '0) &&
		            (((cmd_s1 == CMD_BITMAP_PIXEL) && (mode_q == MODE_BITMAP)) ||
		             ((cmd_s1 == CMD_TICK) && (mode_q == MODE_FILL)));
	end

	// Job build.
	always_comb begin
		job.kind = JOB_REJECT;
		job.x0   = 16'(x_s1);
		job.x1   = 16'(x1);
		job.y0   = 16'(y_s1);
		job.y1   = 16'(y1);
		job.pix  = (cmd_s1 == CMD_TICK) ? fill_color_q : pixel_s1;
		job.done = last_px;
		unique case (cmd_s1)
			CMD_FILL_RECT, CMD_FILL_SCREEN, CMD_OPEN_WINDOW: begin
				if (ok_s1) begin
					job.kind = JOB_WINDOW;
				end
			end
			CMD_BITMAP_PIXEL, CMD_TICK: begin
				if (stream_ok) begin
					job.kind = JOB_PIXEL;
				end
			end
			default: begin
				job.kind = JOB_REJECT;
			end
		endcase
	end

	assign job_valid = valid_s1;

	// Stream state, updated as each job leaves for the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
			fill_color_q  <= '0;
			mode_q        <= MODE_IDLE;
		end else if (push) begin
			if (job.kind == JOB_WINDOW) begin
				pixels_left_q <= COUNT_W'(area);
				if (cmd_s1 == CMD_OPEN_WINDOW) begin
					mode_q <= MODE_BITMAP;
				end else begin
					mode_q       <= MODE_FILL;
					fill_color_q <= pixel_s1;
				end
			end else if (job.kind == JOB_PIXEL) begin
				pixels_left_q <= pixels_left_q - COUNT_W'(1);
				if (last_px) begin
					mode_q <= MODE_IDLE;
				end
			end
		end
	end

endmodule

[rtl/slfs_queue.sv]
// Short job queue between the front and the back.
// Register-based ring with a fill count. Depends on slfs_pkg.
module slfs_queue
	import slfs_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/slfs_back.sv]
// Back part: turns queued jobs into SPI words with their flags.
// One word per cycle into an output register while out_ready does not stall it. Depends on slfs_pkg.
module slfs_back
	import slfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  codes_t     codes,
	input  logic       job_valid,
	output logic       job_ready,
	input  job_t       job,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_is_data,
	output logic       out_last,
	output logic       out_region_done,
	output logic       out_status
);

	logic [BYTE_CNT_W-1:0] cnt_q;
	logic                  valid_q;
	logic [7:0]            byte_q;
	logic                  is_data_q;
	logic                  last_q;
	logic                  done_q;
	logic                  status_q;

	logic                  adv;
	logic                  emit;
	logic                  final_word;
	logic [7:0]            nx_byte;
	logic                  nx_is_data;
	logic                  nx_done;
	logic                  nx_status;

	assign adv       = !valid_q || out_ready;
	assign emit      = adv && job_valid;
	assign job_ready = emit && final_word;

	// Word selection for the head job.
	always_comb begin
		nx_byte    = 8'h00;
		nx_is_data = 1'b0;
		nx_done    = 1'b0;
		nx_status  = 1'b0;
		final_word = 1'b1;
		unique case (job.kind)
			JOB_WINDOW: begin
				final_word = (cnt_q == WINDOW_LAST_IDX);
				nx_is_data = 1'b1;
				case (cnt_q)
					4'd0: begin
						nx_byte    = codes.column_code;
						nx_is_data = 1'b0;
					end
					4'd1: nx_byte = job.x0[15:8];
					4'd2: nx_byte = job.x0[7:0];
					4'd3: nx_byte = job.x1[15:8];
					4'd4: nx_byte = job.x1[7:0];
					4'd5: begin
						nx_byte    = codes.row_code;
						nx_is_data = 1'b0;
					end
					4'd6: nx_byte = job.y0[15:8];
					4'd7: nx_byte = job.y0[7:0];
					4'd8: nx_byte = job.y1[15:8];
					4'd9: nx_byte = job.y1[7:0];
					default: begin
						nx_byte    = codes.memwr_code;
						nx_is_data = 1'b0;
					end
				endcase
			end
			JOB_PIXEL: begin
				final_word = (cnt_q == PIXEL_LAST_IDX);
				nx_is_data = 1'b1;
				nx_byte    = final_word ? job.pix[7:0] : job.pix[15:8];
				nx_done    = final_word && job.done;
			end
			default: begin
				nx_status = 1'b1;
			end
		endcase
	end

	// Word counter within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= job_valid;
			if (emit) begin
				cnt_q <= final_word ? '0 : cnt_q + BYTE_CNT_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q    <= nx_byte;
			is_data_q <= nx_is_data;
			last_q    <= final_word;
			done_q    <= nx_done;
			status_q  <= nx_status;
		end
	end

	assign out_valid       = valid_q;
	assign out_byte        = byte_q;
	assign out_is_data     = is_data_q;
	assign out_last        = last_q;
	assign out_region_done = done_q;
	assign out_status      = status_q;

endmodule

[rtl/spi_lcd_window_fill_streamer.sv]
// Top level of the SPI panel window fill streamer: configuration registers,
// front, job queue and back. Depends on slfs_pkg, slfs_front, slfs_queue, slfs_back.
//
// Channel  | Direction | Handshake           | Contents
// s_*      | in        | s_tvalid / s_tready | one drawing command word
// m_*      | out       | m_tvalid / m_tready | one SPI byte word with its flags
// cfg_*    | in        | cfg_we              | one register write, no wait
//
// A command is registered in the front stage, then waits in the job queue.
// The back sends one word a cycle while m_tready allows: a tick or bitmap pixel gives 2 words,
// a fill or window command 11 words, a rejected command 1 word.
// The back's one-word-per-cycle output register sets the sustained rate while m_tready is high.
// Reset clears stream state, queue and counters; registers take their defaults.
// A stall on m_tready fills the queue and then holds s_tready low.
module spi_lcd_window_fill_streamer
	import slfs_pkg::*;
#(
	parameter int MAX_SIDE    = MAX_SIDE_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [71:0]           s_tdata,   // pos_x, pos_y, size_w, size_h, pixel, zero fill
	input  logic [2:0]            s_tuser,   // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // out_byte
	output logic [2:0]            m_tuser,   // is_data, region_done, status
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [PANEL_W-1:0] panel_width_q;
	logic [PANEL_W-1:0] panel_height_q;
	codes_t             codes_q;

	logic               fq_valid;
	logic               fq_ready;
	job_t               fq_job;
	logic               qb_valid;
	logic               qb_ready;
	job_t               qb_job;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q       <= PANEL_WIDTH_RST;
			panel_height_q      <= PANEL_HEIGHT_RST;
			codes_q.column_code <= COLUMN_CODE_RST;
			codes_q.row_code    <= ROW_CODE_RST;
			codes_q.memwr_code  <= MEMWR_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PANEL_WIDTH:  panel_width_q       <= cfg_data;
				CFG_PANEL_HEIGHT: panel_height_q      <= cfg_data;
				CFG_COLUMN_CODE:  codes_q.column_code <= cfg_data[7:0];
				CFG_ROW_CODE:     codes_q.row_code    <= cfg_data[7:0];
				CFG_MEMWR_CODE:   codes_q.memwr_code  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front: classify and clip.
	slfs_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.panel_width (panel_width_q),
		.panel_height(panel_height_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (s_tuser),
		.in_pos_x    ($signed(s_tdata[12:0])),
		.in_pos_y    ($signed(s_tdata[25:13])),
		.in_size_w   ($signed(s_tdata[38:26])),
		.in_size_h   ($signed(s_tdata[51:39])),
		.in_pixel    (s_tdata[67:52]),
		.job_valid   (fq_valid),
		.job_ready   (fq_ready),
		.job         (fq_job)
	);

	// Job queue.
	slfs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_job),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_job)
	);

	// Back: word sequencing.
	slfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.codes          (codes_q),
		.job_valid      (qb_valid),
		.job_ready      (qb_ready),
		.job            (qb_job),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.out_is_data    (m_tuser[0]),
		.out_last       (m_tlast),
		.out_region_done(m_tuser[1]),
		.out_status     (m_tuser[2])
	);

endmodule

[test/testbench.sv]
// Self-checking testbench for the SPI panel window fill streamer.
// It drives drawing commands, predicts the SPI words and checks the output stream.
// Depends on slfs_pkg and spi_lcd_window_fill_streamer.
module testbench
	import slfs_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 460;
	localparam int PHASES = 8;
	localparam int SETTLE_CYCLES = 30;
	localparam int MAX_STREAMED = 64;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	// One output word as seen on the master side
	typedef struct packed {
		logic [7:0] octet;
		logic       is_data;
		logic       tail;
		logic       region_done;
		logic       status;
	} spi_word_t;

	// One drawing command; typed_reject marks rows whose answer is a plain rejection
	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic signed [12:0] size_w;
		logic signed [12:0] size_h;
		logic [15:0]        pixel;
		logic               typed_reject;
	} draw_cmd_t;

	localparam spi_word_t REJECT_WORD = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [71:0]           s_tdata;
	logic [2:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and of the stream state
	logic [10:0] panel_w;
	logic [10:0] panel_h;
	logic [7:0]  col_code;
	logic [7:0]  row_code;
	logic [7:0]  mwr_code;
	logic [20:0] px_remaining;
	logic [15:0] fill_rgb;
	logic [1:0]  stream_state;

	spi_word_t spi_words_due[$];
	int        fault_count;
	int        cycle_count;
	int        sender_idle_pct;
	int        recv_stall_pct;

	spi_lcd_window_fill_streamer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Opening commands at the reset panel size of 240 by 320
	draw_cmd_t opening_rows [0:24] = '{
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b1},
		'{CMD_BITMAP_PIXEL, 0, 0, 0, 0, 16'h1234, 1'b1},
		'{CMD_UNUSED_FIRST, 0, 0, 1, 1, 16'h0000, 1'b1},
		'{CMD_UNUSED_LAST,  0, 0, 1, 1, 16'hFFFF, 1'b1},
		'{CMD_FILL_RECT,    0, 0, 0, 5, 16'h0000, 1'b1},
		'{CMD_FILL_RECT,    0, 0, 5, -4096, 16'h0000, 1'b1},
		'{CMD_FILL_RECT,    240, 0, 1, 1, 16'h0000, 1'b1},
		'{CMD_FILL_RECT,    -4096, 0, 4095, 1, 16'h0000, 1'b1},
		'{CMD_FILL_RECT,    4095, 4095, 4095, 4095, 16'hFFFF, 1'b1},
		'{CMD_FILL_RECT,    -2, -3, 4, 5, 16'hF800, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b1},
		'{CMD_FILL_RECT,    238, 318, 4095, 4095, 16'h07E0, 1'b0},
		'{CMD_FILL_SCREEN,  0, 0, 0, 0, 16'hFFFF, 1'b0},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_OPEN_WINDOW,  239, 0, 2, 1, 16'h0000, 1'b1},
		'{CMD_OPEN_WINDOW,  -1, 0, 1, 1, 16'h0000, 1'b1},
		'{CMD_TICK,         0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_OPEN_WINDOW,  239, 318, 1, 2, 16'h0000, 1'b0},
		'{CMD_BITMAP_PIXEL, 0, 0, 0, 0, 16'h0000, 1'b0},
		'{CMD_BITMAP_PIXEL, 0, 0, 0, 0, 16'hFFFF, 1'b0},
		'{CMD_BITMAP_PIXEL, 0, 0, 0, 0, 16'hABCD, 1'b1}
	};

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Panel sizes above the maximum side are used as the maximum
	function automatic int clamp_side(input logic [10:0] side);
		return (side > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : int'(side);
	endfunction

	task automatic push_reject();
		spi_words_due.push_back(REJECT_WORD);
	endtask

	// Column window, row window and memory-write command
	task automatic push_window(input int x, input int y, input int w, input int h);
		logic [15:0] x0, x1, y0, y1;
		x0 = 16'(x);
		y0 = 16'(y);
		x1 = 16'(x + w - 1);
		y1 = 16'(y + h - 1);
		spi_words_due.push_back('{col_code, 1'b0, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{x0[15:8], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{x0[7:0], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{x1[15:8], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{x1[7:0], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{row_code, 1'b0, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{y0[15:8], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{y0[7:0], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{y1[15:8], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{y1[7:0], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{mwr_code, 1'b0, 1'b1, 1'b0, 1'b0});
	endtask

	// Clip a fill to the panel and start streaming it, or reject it
	task automatic start_fill(input int x_in, input int y_in, input int w_in, input int h_in,
			input logic [15:0] colour);
		int x, y, w, h, pw, ph;
		x = x_in;
		y = y_in;
		w = w_in;
		h = h_in;
		pw = clamp_side(panel_w);
		ph = clamp_side(panel_h);
		if (w <= 0 || h <= 0) begin
			push_reject();
			return;
		end
		if (x < 0) begin
			w = w + x;
			x = 0;
		end
		if (y < 0) begin
			h = h + y;
			y = 0;
		end
		if (x >= pw || y >= ph || w <= 0 || h <= 0) begin
			push_reject();
			return;
		end
		if (w > pw - x) w = pw - x;
		if (h > ph - y) h = ph - y;
		px_remaining = 21'(w * h);
		fill_rgb = colour;
		stream_state = MODE_FILL;
		push_window(x, y, w, h);
	endtask

	// One pixel as high then low byte; the low byte of the final one closes the region
	task automatic push_pixel(input logic [15:0] colour);
		logic finished;
		px_remaining = px_remaining - 21'd1;
		finished = (px_remaining == 21'd0);
		if (finished) stream_state = MODE_IDLE;
		spi_words_due.push_back('{colour[15:8], 1'b1, 1'b0, 1'b0, 1'b0});
		spi_words_due.push_back('{colour[7:0], 1'b1, 1'b1, finished, 1'b0});
	endtask

	// Predict the SPI words caused by one accepted command
	task automatic forecast_spi_words(input draw_cmd_t item);
		int x, y, w, h, pw, ph;
		x = item.pos_x;
		y = item.pos_y;
		w = item.size_w;
		h = item.size_h;
		pw = clamp_side(panel_w);
		ph = clamp_side(panel_h);
		case (item.cmd)
			CMD_FILL_RECT: begin
				start_fill(x, y, w, h, item.pixel);
			end
			CMD_FILL_SCREEN: begin
				start_fill(0, 0, pw, ph, item.pixel);
			end
			CMD_OPEN_WINDOW: begin
				if (w <= 0 || h <= 0 || x < 0 || y < 0 || x > pw - w || y > ph - h) begin
					push_reject();
				end else begin
					px_remaining = 21'(w * h);
					stream_state = MODE_BITMAP;
					push_window(x, y, w, h);
				end
			end
			CMD_BITMAP_PIXEL: begin
				if (stream_state != MODE_BITMAP || px_remaining == 21'd0) push_reject();
				else push_pixel(item.pixel);
			end
			CMD_TICK: begin
				if (stream_state != MODE_FILL || px_remaining == 21'd0) push_reject();
				else push_pixel(fill_rgb);
			end
			default: begin
				push_reject();
			end
		endcase
	endtask

	// Offer one command at the falling edge and hold it until it is taken
	task automatic send_word(input draw_cmd_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = item.cmd;
		s_tdata = {4'b0, item.pixel, item.size_h, item.size_w, item.pos_y, item.pos_x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (item.typed_reject) push_reject();
		else forecast_spi_words(item);
	endtask

	// Register write, mirrored into the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		s_tvalid = 1'b0;
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PANEL_WIDTH:  panel_w = value;
			CFG_PANEL_HEIGHT: panel_h = value;
			CFG_COLUMN_CODE:  col_code = value[7:0];
			CFG_ROW_CODE:     row_code = value[7:0];
			CFG_MEMWR_CODE:   mwr_code = value[7:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (spi_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_fault(input string msg);
		if (fault_count < 10) $display("%s", msg);
		fault_count++;
	endtask

	// Receiver back-pressure, changed at the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each accepted word with the oldest expected one
	always @(posedge clk) begin
		spi_word_t want;
		spi_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
			if (spi_words_due.size() == 0) begin
				report_fault($sformatf("unexpected word: byte %02h data %0b last %0b done %0b st %0b",
					got.octet, got.is_data, got.tail, got.region_done, got.status));
			end else begin
				want = spi_words_due.pop_front();
				if (got.octet !== want.octet || got.is_data !== want.is_data ||
						got.tail !== want.tail || got.region_done !== want.region_done ||
						got.status !== want.status) begin
					report_fault($sformatf(
						"word mismatch: expected %02h/%0b/%0b/%0b/%0b got %02h/%0b/%0b/%0b/%0b",
						want.octet, want.is_data, want.tail, want.region_done, want.status,
						got.octet, got.is_data, got.tail, got.region_done, got.status));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stimulus
	initial begin
		draw_cmd_t item;
		logic [2:0] follow_cmd;
		int phase, sent, pick, n, pw, ph;
		logic [10:0] new_w, new_h;
		logic [7:0] new_col, new_row, new_mwr;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fault_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		panel_w = PANEL_WIDTH_RST;
		panel_h = PANEL_HEIGHT_RST;
		col_code = COLUMN_CODE_RST;
		row_code = ROW_CODE_RST;
		mwr_code = MEMWR_CODE_RST;
		px_remaining = '0;
		fill_rgb = '0;
		stream_state = MODE_IDLE;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed commands at the reset settings
		foreach (opening_rows[i]) send_word(opening_rows[i]);
		wait_drained();

		// Random phases, each with its own panel, codes and idling pattern
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					new_w = PANEL_WIDTH_RST; new_h = PANEL_HEIGHT_RST;
					new_col = COLUMN_CODE_RST; new_row = ROW_CODE_RST; new_mwr = MEMWR_CODE_RST;
				end
				1: begin
					new_w = 11'd1; new_h = 11'd1;
					new_col = 8'h00; new_row = 8'h00; new_mwr = 8'h00;
				end
				2: begin
					new_w = 11'd2047; new_h = 11'd2047;
					new_col = 8'hFF; new_row = 8'hFF; new_mwr = 8'hFF;
				end
				3: begin
					new_w = 11'd0; new_h = 11'($urandom_range(1, 30));
					new_col = 8'($urandom); new_row = 8'($urandom); new_mwr = 8'($urandom);
				end
				4: begin
					new_w = 11'd1024; new_h = 11'd1;
					new_col = 8'($urandom); new_row = 8'($urandom); new_mwr = 8'($urandom);
				end
				6: begin
					new_w = 11'd1025; new_h = 11'd0;
					new_col = 8'($urandom); new_row = 8'($urandom); new_mwr = 8'($urandom);
				end
				default: begin
					new_w = 11'($urandom_range(1, 40)); new_h = 11'($urandom_range(1, 40));
					new_col = 8'($urandom); new_row = 8'($urandom); new_mwr = 8'($urandom);
				end
			endcase
			write_reg(CFG_PANEL_WIDTH, new_w);
			write_reg(CFG_PANEL_HEIGHT, new_h);
			write_reg(CFG_COLUMN_CODE, CFG_DATA_W'(new_col));
			write_reg(CFG_ROW_CODE, CFG_DATA_W'(new_row));
			write_reg(CFG_MEMWR_CODE, CFG_DATA_W'(new_mwr));

			case (phase % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
			endcase

			pw = clamp_side(panel_w);
			ph = clamp_side(panel_h);
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				pick = $urandom_range(0, 99);
				item = '{default: '0};
				item.pixel = 16'($urandom);
				follow_cmd = CMD_TICK;
				if (pick < 40) begin
					// Small fill anywhere on the panel or just past its edges, then its ticks
					item.cmd = CMD_FILL_RECT;
					item.pos_x = 13'($urandom_range(0, pw + 4) - 3);
					item.pos_y = 13'($urandom_range(0, ph + 4) - 3);
					n = ($urandom_range(0, 9) == 0) ? 12 : 4;
					item.size_w = 13'($urandom_range(1, n));
					item.size_h = 13'($urandom_range(1, n));
				end else if (pick < 62) begin
					// Bitmap window, sometimes hanging off the panel, then its pixels
					item.cmd = CMD_OPEN_WINDOW;
					follow_cmd = CMD_BITMAP_PIXEL;
					item.pos_x = 13'($urandom_range(0, pw + 1) - 1);
					item.pos_y = 13'($urandom_range(0, ph + 1) - 1);
					item.size_w = 13'($urandom_range(1, 4));
					item.size_h = 13'($urandom_range(1, 4));
				end else if (pick < 67) begin
					item.cmd = CMD_FILL_SCREEN;
					item.pos_x = 13'($urandom);
					item.pos_y = 13'($urandom);
					item.size_w = 13'($urandom);
					item.size_h = 13'($urandom);
				end else begin
					// Anything at all, including the unused codes
					item.cmd = 3'($urandom_range(0, 7));
					item.pos_x = 13'($urandom);
					item.pos_y = 13'($urandom);
					item.size_w = 13'($urandom);
					item.size_h = 13'($urandom);
					follow_cmd = CMD_UNUSED_FIRST;
				end
				send_word(item);
				sent++;

				// Stream the region out; now and then stop short or run one past the end
				if (follow_cmd != CMD_UNUSED_FIRST && stream_state != MODE_IDLE &&
						px_remaining <= MAX_STREAMED) begin
					n = px_remaining;
					pick = $urandom_range(0, 9);
					if (pick == 0) n = n + 1;
					else if (pick == 1) n = n / 2;
					repeat (n) begin
						item.cmd = follow_cmd;
						item.pos_x = 13'($urandom);
						item.pos_y = 13'($urandom);
						item.size_w = 13'($urandom);
						item.size_h = 13'($urandom);
						item.pixel = 16'($urandom);
						send_word(item);
						sent++;
					end
				end
			end
			wait_drained();
		end

		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
